// ----- hw/rtl/pls_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pls_pkg;

	// default sizes of the list store
	localparam int CAPACITY_DEF   = 64;
	localparam int DATA_WIDTH_DEF = 32;

	// fixed field widths of the command and result beats
	localparam int OP_W     = 2;
	localparam int POS_W    = 7;
	localparam int ELEM_W   = 32;
	localparam int STATUS_W = 2;
	localparam int CNT_W    = 7;

	// operation codes
	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_READ   = 2'd2
	} op_t;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_SHIFT,
		S_PUT,
		S_RD,
		S_RDW
	} state_t;

	// command beat
	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [POS_W-1:0]  position;
		logic [ELEM_W-1:0] element;
	} req_t;

	// result beat
	typedef struct packed {
		status_t           status;
		logic [ELEM_W-1:0] read_data;
		logic [CNT_W-1:0]  entry_count;
	} rsp_t;

	// memory port strobes
	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} mem_ctl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/pls_mem.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pls_mem #(
	parameter int DEPTH = pls_pkg::CAPACITY_DEF,
	parameter int WIDTH = pls_pkg::DATA_WIDTH_DEF
) (
	input  wire logic                     clk,
	input  wire pls_pkg::mem_ctl_t        ctl,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ----- hw/rtl/pls_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pls_ctrl #(
	parameter int CAPACITY   = pls_pkg::CAPACITY_DEF,
	parameter int DATA_WIDTH = pls_pkg::DATA_WIDTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire pls_pkg::req_t               req,
	output logic                             done,
	output pls_pkg::rsp_t                    rsp,
	output pls_pkg::mem_ctl_t                mem_ctl,
	output logic [$clog2(CAPACITY)-1:0]      mem_waddr,
	output logic [DATA_WIDTH-1:0]            mem_wdata,
	output logic [$clog2(CAPACITY)-1:0]      mem_raddr,
	input  wire logic [DATA_WIDTH-1:0]       mem_rdata
);

	localparam int AW    = $clog2(CAPACITY);
	localparam int CW    = $clog2(CAPACITY + 1);
	localparam int PW    = pls_pkg::POS_W;
	localparam int CMPW  = (CW > PW) ? CW : PW;
	localparam int OCW   = pls_pkg::CNT_W;
	localparam int EW    = pls_pkg::ELEM_W;

	pls_pkg::state_t state_q, state_d;
	logic [CW-1:0]         count_q, count_d;
	logic                  rd_act_q, rd_act_d;
	logic                  wb_s1, wb_d;
	logic                  done_q, done_d;
	logic [AW-1:0]         ptr_q, ptr_d;
	logic [AW-1:0]         end_q, end_d;
	logic [AW-1:0]         slot_q, slot_d;
	logic [AW-1:0]         wb_addr_s1, wb_addr_d;
	logic                  ins_q, ins_d;
	logic [DATA_WIDTH-1:0] word_q, word_d;
	pls_pkg::rsp_t         rsp_q, rsp_d;

	logic [CMPW-1:0]       pos_ext;
	logic [CMPW-1:0]       cnt_ext;
	logic [CMPW-1:0]       cap_ext;
	logic [63:0]           elem_wide;
	logic [63:0]           rd_wide;

	// operand alignment
	always_comb begin
		pos_ext   = CMPW'(req.position);
		cnt_ext   = CMPW'(count_q);
		cap_ext   = CMPW'(CAPACITY);
		elem_wide = 64'(req.element);
		rd_wide   = 64'(mem_rdata);
	end

	// next state, shift sequencing and memory port drive
	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		rd_act_d   = rd_act_q;
		wb_d       = 1'b0;
		done_d     = 1'b0;
		ptr_d      = ptr_q;
		end_d      = end_q;
		slot_d     = slot_q;
		wb_addr_d  = wb_addr_s1;
		ins_d      = ins_q;
		word_d     = word_q;
		rsp_d      = rsp_q;
		mem_ctl    = '0;
		mem_waddr  = wb_addr_s1;
		mem_wdata  = mem_rdata;
		mem_raddr  = ptr_q;

		unique case (state_q)
			pls_pkg::S_IDLE: begin
				if (start) begin
					rsp_d.status    = pls_pkg::ST_OK;
					rsp_d.read_data = '0;
					case (req.op)
						pls_pkg::OP_INSERT: begin
							if (cnt_ext >= cap_ext) begin
								rsp_d.status = pls_pkg::ST_FULL;
								done_d       = 1'b1;
							end else begin
								ins_d  = 1'b1;
								word_d = elem_wide[DATA_WIDTH-1:0];
								if (pos_ext < cnt_ext) begin
									slot_d   = AW'(pos_ext);
									end_d    = AW'(pos_ext);
									ptr_d    = AW'(cnt_ext - 1'b1);
									rd_act_d = 1'b1;
									state_d  = pls_pkg::S_SHIFT;
								end else begin
									slot_d  = AW'(cnt_ext);
									state_d = pls_pkg::S_PUT;
								end
							end
						end
						pls_pkg::OP_DELETE: begin
							if (count_q == '0) begin
								rsp_d.status = pls_pkg::ST_EMPTY;
								done_d       = 1'b1;
							end else if (pos_ext < cnt_ext - 1'b1) begin
								ins_d    = 1'b0;
								ptr_d    = AW'(pos_ext + 1'b1);
								end_d    = AW'(cnt_ext - 1'b1);
								rd_act_d = 1'b1;
								state_d  = pls_pkg::S_SHIFT;
							end else begin
								// last entry goes, nothing to move
								count_d = count_q - 1'b1;
								done_d  = 1'b1;
							end
						end
						pls_pkg::OP_READ: begin
							if (pos_ext >= cnt_ext) begin
								rsp_d.status = pls_pkg::ST_RANGE;
								done_d       = 1'b1;
							end else begin
								ptr_d   = AW'(pos_ext);
								state_d = pls_pkg::S_RD;
							end
						end
						default: begin
							done_d = 1'b1;
						end
					endcase
				end
			end
			pls_pkg::S_SHIFT: begin
				// read one entry ahead, write the previous one back to its neighbor
				mem_ctl.rd_en = rd_act_q;
				mem_ctl.wr_en = wb_s1;
				wb_d          = rd_act_q;
				wb_addr_d     = ins_q ? AW'(ptr_q + 1'b1) : AW'(ptr_q - 1'b1);
				if (rd_act_q) begin
					if (ptr_q == end_q) begin
						rd_act_d = 1'b0;
					end else begin
						ptr_d = ins_q ? AW'(ptr_q - 1'b1) : AW'(ptr_q + 1'b1);
					end
				end else if (ins_q) begin
					state_d = pls_pkg::S_PUT;
				end else begin
					count_d = count_q - 1'b1;
					done_d  = 1'b1;
					state_d = pls_pkg::S_IDLE;
				end
			end
			pls_pkg::S_PUT: begin
				mem_ctl.wr_en = 1'b1;
				mem_waddr     = slot_q;
				mem_wdata     = word_q;
				count_d       = count_q + 1'b1;
				done_d        = 1'b1;
				state_d       = pls_pkg::S_IDLE;
			end
			pls_pkg::S_RD: begin
				mem_ctl.rd_en = 1'b1;
				state_d       = pls_pkg::S_RDW;
			end
			pls_pkg::S_RDW: begin
				rsp_d.read_data = rd_wide[EW-1:0];
				done_d          = 1'b1;
				state_d         = pls_pkg::S_IDLE;
			end
			default: begin
				state_d = pls_pkg::S_IDLE;
			end
		endcase

		if (done_d) begin
			rsp_d.entry_count = OCW'(count_d);
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pls_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			rd_act_q <= 1'b0;
			wb_s1    <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			count_q  <= count_d;
			rd_act_q <= rd_act_d;
			wb_s1    <= wb_d;
			done_q   <= done_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		ptr_q      <= ptr_d;
		end_q      <= end_d;
		slot_q     <= slot_d;
		wb_addr_s1 <= wb_addr_d;
		ins_q      <= ins_d;
		word_q     <= word_d;
		rsp_q      <= rsp_d;
	end

	assign busy = (state_q != pls_pkg::S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

`ifndef SYNTH
	// count stays within capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	// full status only reported on a full list
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && rsp_q.status == pls_pkg::ST_FULL) |-> (count_q == CW'(CAPACITY)))
		else $error("full status with room left");

	// write and read never hit the same entry in one cycle
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_ctl.wr_en && mem_ctl.rd_en) |-> (mem_waddr != mem_raddr))
		else $error("read and write to same entry");

	// shift drains with a pending write-back once reading stops
	a_shift_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pls_pkg::S_SHIFT && !rd_act_q) |-> wb_s1)
		else $error("shift ended without write-back");

	// a result strobe always follows a busy cycle or an idle accept
	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy || start))
		else $error("result without command");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/positional_list_store_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Bounded positional list store: an ordered list of up to CAPACITY words.
// Command channel: a beat on req is taken at a clock edge with start high
// and busy low. op selects insert at position, delete at position or read
// at position; for insert and delete a position at or past the end means
// the end of the list, a read there is out of range. Result channel: done
// is high for exactly one cycle with the result on rsp (status, read word,
// entry count after the operation). The receiver cannot stall; every
// command gives one result, in command order. Full, empty, out of range,
// unused op and delete of the last entry need no memory access. A read
// reads the memory, then registers the word; an append writes the slot;
// an insert at p moves entries p and up one place up, then writes the
// slot; a delete at p moves the entries above p one place down. The shift
// runs through the single memory, one entry moved per cycle with the read
// one entry ahead of the write. busy stays high until the result is registered.
// Reset clears the entry count and the sequencer; the word memory is not
// cleared and an entry is only read after it was written.

module positional_list_store_unit #(
	parameter int CAPACITY   = pls_pkg::CAPACITY_DEF,
	parameter int DATA_WIDTH = pls_pkg::DATA_WIDTH_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire pls_pkg::req_t req,
	output logic               done,
	output pls_pkg::rsp_t      rsp
);

	localparam int AW = $clog2(CAPACITY);

	pls_pkg::mem_ctl_t     mem_ctl;
	logic [AW-1:0]         mem_waddr;
	logic [AW-1:0]         mem_raddr;
	logic [DATA_WIDTH-1:0] mem_wdata;
	logic [DATA_WIDTH-1:0] mem_rdata;

	// sequencer and entry count
	pls_ctrl #(
		.CAPACITY   (CAPACITY),
		.DATA_WIDTH (DATA_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.rsp       (rsp),
		.mem_ctl   (mem_ctl),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	// entry storage
	pls_mem #(
		.DEPTH (CAPACITY),
		.WIDTH (DATA_WIDTH)
	) u_mem (
		.clk   (clk),
		.ctl   (mem_ctl),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

`default_nettype wire
